// File: hw/rtl/rvwma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvwma_pkg
// Shared widths, reset values, controller states and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rvwma_pkg;

	localparam int unsigned FIELD_W        = 24;
	localparam int unsigned WLEN_W         = 9;
	localparam int unsigned WSUM_W         = 56;
	localparam int unsigned VSUM_W         = 32;
	localparam int unsigned PROD_W         = 2 * FIELD_W;
	localparam int unsigned QCNT_W         = $clog2(WSUM_W);
	localparam int unsigned WINDOW_MAX_DEF = 256;

	localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(14);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OLD,
		S_NEW,
		S_ACC,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mult_old;
		logic mult_new;
		logic accum;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_sum;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/rvwma_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvwma_div
// Restoring divider, one quotient bit per cycle while step is high, for the
// weighted sum over the volume sum.
// ----------------------------------------------------------------------------
module rvwma_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          step,
	input  wire logic [rvwma_pkg::WSUM_W-1:0]  dividend,
	input  wire logic [rvwma_pkg::VSUM_W-1:0]  divisor,
	output logic      [rvwma_pkg::WSUM_W-1:0]  quotient,
	output logic                               last
);

	logic [rvwma_pkg::WSUM_W-1:0] quo_q;
	logic [rvwma_pkg::VSUM_W-1:0] rem_q;
	logic [rvwma_pkg::QCNT_W-1:0] cnt_q;
	logic [rvwma_pkg::VSUM_W:0]   rem_ext;
	logic [rvwma_pkg::VSUM_W+1:0] diff;
	logic                         fits;

	// shift in the next dividend bit, try to take the divisor off
	assign rem_ext = {rem_q, quo_q[rvwma_pkg::WSUM_W-1]};
	assign diff    = {1'b0, rem_ext} - {2'b00, divisor};
	assign fits    = ~diff[rvwma_pkg::VSUM_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			quo_q <= {quo_q[rvwma_pkg::WSUM_W-2:0], fits};
			rem_q <= fits ? diff[rvwma_pkg::VSUM_W-1:0] : rem_ext[rvwma_pkg::VSUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + rvwma_pkg::QCNT_W'(1);
		end
	end

	assign last     = (cnt_q == rvwma_pkg::QCNT_W'(rvwma_pkg::WSUM_W - 1));
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/rvwma_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvwma_datapath
// Sample ring, running sums, shared multiplier, divider and result register.
// ----------------------------------------------------------------------------
module rvwma_datapath #(
	parameter int unsigned WINDOW_MAX = rvwma_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rvwma_pkg::dp_cmd_t            cmd,
	output rvwma_pkg::dp_status_t              status,
	input  wire logic                          cfg_we,
	input  wire logic [rvwma_pkg::WLEN_W-1:0]  cfg_wdata,
	input  wire logic [rvwma_pkg::FIELD_W-1:0] price,
	input  wire logic [rvwma_pkg::FIELD_W-1:0] volume,
	output logic      [rvwma_pkg::FIELD_W-1:0] average,
	output logic                               zero_volume
);

	localparam int unsigned FW    = rvwma_pkg::FIELD_W;
	localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CMP_W = (LEN_W > rvwma_pkg::WLEN_W) ? LEN_W : rvwma_pkg::WLEN_W;

	logic [rvwma_pkg::WLEN_W-1:0] wlen_q;
	logic [PTR_W-1:0]             ptr_q;
	logic                         wrapped_q;
	logic [rvwma_pkg::WSUM_W-1:0] ws_q;
	logic [rvwma_pkg::VSUM_W-1:0] vsum_q;

	logic [2*FW-1:0]              ring_mem [WINDOW_MAX];
	logic [2*FW-1:0]              rd_q;
	logic [FW-1:0]                price_q;
	logic [FW-1:0]                volume_q;
	logic [rvwma_pkg::PROD_W-1:0] prod_q;
	logic [FW-1:0]                average_q;
	logic                         zero_q;

	logic [CMP_W-1:0]             wlen_ext;
	logic [CMP_W-1:0]             max_ext;
	logic [CMP_W-1:0]             len_eff;
	logic [CMP_W-1:0]             ptr_inc;
	logic                         wrap;
	logic [FW-1:0]                old_p;
	logic [FW-1:0]                old_v;
	logic [FW-1:0]                mul_a;
	logic [FW-1:0]                mul_b;
	logic [rvwma_pkg::PROD_W-1:0] mul_res;
	logic [rvwma_pkg::WSUM_W-1:0] ws_next;
	logic [rvwma_pkg::WSUM_W-1:0] quotient;
	logic                         div_last;
	logic                         vsum_zero;

	// window length: zero counts as one, above the ring depth saturates
	assign wlen_ext = CMP_W'(wlen_q);
	assign max_ext  = CMP_W'(WINDOW_MAX);
	assign len_eff  = (wlen_ext == '0) ? CMP_W'(1) :
	                  ((wlen_ext > max_ext) ? max_ext : wlen_ext);
	assign ptr_inc  = CMP_W'(ptr_q) + CMP_W'(1);
	assign wrap     = (ptr_inc >= len_eff);

	// entries not yet written since the last clear weigh nothing
	assign old_p = wrapped_q ? rd_q[2*FW-1:FW] : '0;
	assign old_v = wrapped_q ? rd_q[FW-1:0]    : '0;

	assign mul_a   = cmd.mult_old ? old_p : price_q;
	assign mul_b   = cmd.mult_old ? old_v : volume_q;
	assign mul_res = rvwma_pkg::PROD_W'(mul_a) * rvwma_pkg::PROD_W'(mul_b);

	assign ws_next   = ws_q + rvwma_pkg::WSUM_W'(prod_q);
	assign vsum_zero = (vsum_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q     <= ring_mem[ptr_q];
			price_q  <= price;
			volume_q <= volume;
		end
		if (cmd.mult_old) begin
			ring_mem[ptr_q] <= {price_q, volume_q};
		end
		if (cmd.mult_old || cmd.mult_new) begin
			prod_q <= mul_res;
		end
		if (cmd.out_load) begin
			zero_q <= vsum_zero;
			if (vsum_zero) begin
				average_q <= '0;
			end else if (|quotient[rvwma_pkg::WSUM_W-1:FW]) begin
				average_q <= '1;
			end else begin
				average_q <= quotient[FW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= rvwma_pkg::WLEN_RESET;
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
			ws_q      <= '0;
			vsum_q    <= '0;
		end else if (cfg_we) begin
			wlen_q    <= cfg_wdata;
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
			ws_q      <= '0;
			vsum_q    <= '0;
		end else begin
			if (cmd.mult_old) begin
				vsum_q <= vsum_q - rvwma_pkg::VSUM_W'(old_v) + rvwma_pkg::VSUM_W'(volume_q);
				if (wrap) begin
					ptr_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					ptr_q <= ptr_inc[PTR_W-1:0];
				end
			end
			if (cmd.mult_new) begin
				ws_q <= ws_q - rvwma_pkg::WSUM_W'(prod_q);
			end
			if (cmd.accum) begin
				ws_q <= ws_next;
			end
		end
	end

	rvwma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.accum),
		.step     (cmd.div_step),
		.dividend (ws_next),
		.divisor  (vsum_q),
		.quotient (quotient),
		.last     (div_last)
	);

	assign status.zero_sum = vsum_zero;
	assign status.div_last = div_last;
	assign average         = average_q;
	assign zero_volume     = zero_q;

endmodule
`default_nettype wire

// File: hw/rtl/rvwma_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvwma_ctrl
// Sequencer for one item: ring read, sum update, divide, result handover.
// ----------------------------------------------------------------------------
module rvwma_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire rvwma_pkg::dp_status_t status,
	output rvwma_pkg::dp_cmd_t         cmd
);

	rvwma_pkg::state_t state_q;
	rvwma_pkg::state_t state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rvwma_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = rvwma_pkg::S_OLD;
				end
			end
			rvwma_pkg::S_OLD: state_d = rvwma_pkg::S_NEW;
			rvwma_pkg::S_NEW: state_d = rvwma_pkg::S_ACC;
			rvwma_pkg::S_ACC: begin
				state_d = status.zero_sum ? rvwma_pkg::S_DONE : rvwma_pkg::S_DIV;
			end
			rvwma_pkg::S_DIV: begin
				if (status.div_last) begin
					state_d = rvwma_pkg::S_DONE;
				end
			end
			rvwma_pkg::S_DONE: begin
				if (out_free) begin
					state_d = rvwma_pkg::S_IDLE;
				end
			end
			default: state_d = rvwma_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rvwma_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			rvwma_pkg::S_OLD:  cmd.mult_old = 1'b1;
			rvwma_pkg::S_NEW:  cmd.mult_new = 1'b1;
			rvwma_pkg::S_ACC:  cmd.accum    = 1'b1;
			rvwma_pkg::S_DIV:  cmd.div_step = 1'b1;
			rvwma_pkg::S_DONE: cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rvwma_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: hw/rtl/rolling_vwma.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rolling_vwma
// Rolling volume weighted moving average over a programmable window.
// ----------------------------------------------------------------------------
// Each input item carries a price (16.8 unsigned fixed point) and an integer
// volume; each item gives exactly one result, the average of the last
// window_length prices weighted by their volumes, truncated, in the price's
// format. Until the window has filled, the missing samples weigh nothing.
// When the volumes in the window sum to zero the average reads 0 and
// zero_volume is set. window_length 0 counts as 1 and values above
// WINDOW_MAX saturate; any write to it empties the window and both sums.
// Sequence: the ring is read at the accepting edge; the sums are updated in
// the OLD, NEW and ACC states through one shared 24x24 multiplier; the
// restoring divider then gives one quotient bit per cycle; and the result
// register loads in the DONE state, which waits while an earlier result is
// still unread. The divide is skipped when the volume sum is zero. The block
// takes one item at a time: the next is accepted in the idle state after the
// result has loaded. Most of an item's time is spent in the divider. A
// finished result waits in its own register, so the next item is taken while
// it is still unread. No clearing pass is needed after reset or a window
// write: a wrap flag marks ring entries not yet written.
// ----------------------------------------------------------------------------
module rolling_vwma #(
	parameter int unsigned WINDOW_MAX = rvwma_pkg::WINDOW_MAX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// window length register
	input  wire logic                          cfg_we,
	input  wire logic [rvwma_pkg::WLEN_W-1:0]  cfg_wdata,
	// sample items
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [rvwma_pkg::FIELD_W-1:0] price,
	input  wire logic [rvwma_pkg::FIELD_W-1:0] volume,
	// average items
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [rvwma_pkg::FIELD_W-1:0] average,
	output logic                               zero_volume
);

	rvwma_pkg::dp_cmd_t    cmd;
	rvwma_pkg::dp_status_t status;

	// sequence the item through read, update, divide and handover
	rvwma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// hold the ring, sums, divider and result register
	rvwma_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.price       (price),
		.volume      (volume),
		.average     (average),
		.zero_volume (zero_volume)
	);

endmodule
`default_nettype wire

// File: hw/rtl/rvwma_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rvwma_checker
// Port-level checks on the averaging block, bound to the top level.
// ----------------------------------------------------------------------------
module rvwma_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rvwma_pkg::FIELD_W-1:0] average,
	input wire logic                          zero_volume
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average) && $stable(zero_volume))
		else $error("result changed while stalled");

	// a zero volume sum forces the average to zero
	a_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_volume |-> average == '0)
		else $error("zero volume with non-zero average");

	// one item at a time: input closes once an item is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// a result appears only from a busy block
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without an item in work");

endmodule

bind rolling_vwma rvwma_checker u_rvwma_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.average     (average),
	.zero_volume (zero_volume)
);
`default_nettype wire
